>>> sv/skt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_pkg: shared types and constants for the sorted key table
// Request and result payloads, opcodes, status codes, sequencer states and
// the internal storage port.
// ----------------------------------------------------------------------------
package skt_pkg;

    // Table geometry
    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int KEY_W = 32;
    localparam int AGE_W = 8;
    localparam int POS_W = 4;
    localparam int ECNT_W = 5;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // Operation codes
    typedef enum logic [1:0] {
        OP_SEARCH = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_CLEAR  = 2'd3
    } kind_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_DUP       = 2'd3
    } status_t;

    // Request payload
    typedef struct packed {
        kind_t                   kind;
        logic signed [KEY_W-1:0] key;
        logic [AGE_W-1:0]        age;
    } in_t;

    // Result payload
    typedef struct packed {
        status_t           status;
        logic [POS_W-1:0]  position;
        logic [AGE_W-1:0]  found_age;
        logic [ECNT_W-1:0] entry_count;
    } out_t;

    // One stored record
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [AGE_W-1:0]        age;
    } entry_t;

    // Storage port driven by the sequencer
    typedef struct packed {
        logic   wr_en;
        idx_t   wr_addr;
        entry_t wr_data;
        idx_t   rd_addr;
    } store_req_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_PLACE,
        S_REPLY
    } state_t;

endpackage

>>> sv/sorted_key_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table: ordered table of signed keys with payloads
// Search, insert, delete and clear on up to DEPTH records kept in ascending
// key order; every request returns one result with the entry count.
//
//   Channel   Ports                     Payload
//   request   s_valid, s_ready, s_data  in_t  (kind, key, age)
//   result    m_valid, m_ready, m_data  out_t (status, position, found_age,
//                                              entry_count)
//
// A search walks the entries in order from entry zero, and an insert or
// delete that moves entries then shifts them one place at a time.
// Clear and full-table inserts skip the walk.
// The walk and the moves both go through the single read port of the store.
// Reset is synchronous, active low, and empties the table.
// The result sits in an output register; a stalled result blocks only the
// request after the one in flight.
// ----------------------------------------------------------------------------
module sorted_key_table
    import skt_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    store_req_t mem_req;
    entry_t     mem_rd;
    logic       res_valid;
    logic       res_ready;
    out_t       res_data;
    logic       m_valid_reg, m_valid_next;
    out_t       m_data_reg, m_data_next;

    skt_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .res_valid (res_valid),
        .res_data  (res_data),
        .res_ready (res_ready),
        .mem_req   (mem_req),
        .mem_rd    (mem_rd)
    );

    skt_store u_store (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (mem_rd)
    );

    // Output register: free when empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
            if (res_valid) begin
                m_data_next = res_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> sv/skt_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_store: record storage
// DEPTH entries of key and payload, one write port and one read port with
// registered read data.
// ----------------------------------------------------------------------------
module skt_store
    import skt_pkg::*;
(
    input  logic       aclk,
    input  store_req_t req,
    output entry_t     rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[req.rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/skt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_ctrl: table sequencer
// Walks the stored entries through one signed compare unit, then moves
// entries one per cycle to open or close a slot, and builds the result.
// ----------------------------------------------------------------------------
module skt_ctrl
    import skt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_t        s_data,
    output logic       res_valid,
    output out_t       res_data,
    input  logic       res_ready,
    output store_req_t mem_req,
    input  entry_t     mem_rd
);

    localparam cnt_t CNT_ONE  = cnt_t'(1);
    localparam cnt_t CNT_FULL = cnt_t'(DEPTH);

    state_t state_reg, state_next;
    kind_t  kind_reg, kind_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [AGE_W-1:0] age_reg, age_next;
    cnt_t   count_reg, count_next;
    idx_t   idx_reg, idx_next;
    idx_t   ptr_reg, ptr_next;
    cnt_t   left_reg, left_next;
    logic   pend_reg, pend_next;
    idx_t   pend_addr_reg, pend_addr_next;
    out_t   result_reg, result_next;

    logic   accept;
    logic   key_lt;
    logic   key_eq;
    cnt_t   idx_inc;
    logic   scan_more;
    logic   scan_match;
    idx_t   scan_pos;

    assign accept = s_valid && s_ready;

    // Shared compare unit: stored key against request key
    assign key_lt     = mem_rd.key < key_reg;
    assign key_eq     = mem_rd.key == key_reg;
    assign idx_inc    = cnt_t'(idx_reg) + CNT_ONE;
    assign scan_more  = key_lt && (idx_inc < count_reg);
    assign scan_match = !key_lt && key_eq;
    assign scan_pos   = key_lt ? idx_t'(count_reg) : idx_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_data.kind == OP_CLEAR) begin
                        state_next = S_REPLY;
                    end else if (s_data.kind == OP_INSERT && count_reg == CNT_FULL) begin
                        state_next = S_REPLY;
                    end else if (count_reg == '0) begin
                        state_next = (s_data.kind == OP_INSERT) ? S_PLACE : S_REPLY;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (!scan_more) begin
                    if (kind_reg == OP_SEARCH) begin
                        state_next = S_REPLY;
                    end else if (kind_reg == OP_INSERT) begin
                        state_next = scan_match ? S_REPLY : S_SHIFT;
                    end else begin
                        state_next = scan_match ? S_SHIFT : S_REPLY;
                    end
                end
            end
            S_SHIFT: begin
                if (left_reg == '0) begin
                    state_next = (kind_reg == OP_INSERT) ? S_PLACE : S_REPLY;
                end
            end
            S_PLACE: begin
                state_next = S_REPLY;
            end
            S_REPLY: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and storage control
    always_comb begin
        kind_next      = kind_reg;
        key_next       = key_reg;
        age_next       = age_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        ptr_next       = ptr_reg;
        left_next      = left_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        result_next    = result_reg;
        mem_req        = '0;

        case (state_reg)
            S_IDLE: begin
                // Latch the request and start the walk at entry zero
                if (accept) begin
                    kind_next = s_data.kind;
                    key_next  = s_data.key;
                    age_next  = s_data.age;
                    idx_next  = '0;
                    left_next = '0;
                    pend_next = 1'b0;
                    result_next = '0;
                    result_next.status = ST_NOT_FOUND;
                    result_next.entry_count = ECNT_W'(count_reg);
                    if (s_data.kind == OP_CLEAR) begin
                        count_next = '0;
                        result_next.status = ST_OK;
                        result_next.entry_count = '0;
                    end else if (s_data.kind == OP_INSERT && count_reg == CNT_FULL) begin
                        result_next.status = ST_FULL;
                    end
                end
            end
            S_SCAN: begin
                if (scan_more) begin
                    idx_next        = idx_t'(idx_inc);
                    mem_req.rd_addr = idx_t'(idx_inc);
                end else begin
                    idx_next  = scan_pos;
                    pend_next = 1'b0;
                    case (kind_reg)
                        OP_SEARCH: begin
                            if (scan_match) begin
                                result_next.status    = ST_OK;
                                result_next.position  = POS_W'(idx_reg);
                                result_next.found_age = mem_rd.age;
                            end
                        end
                        OP_INSERT: begin
                            // Entries from the slot up move one place higher
                            if (scan_match) begin
                                result_next.status = ST_DUP;
                            end
                            left_next = count_reg - cnt_t'(scan_pos);
                            ptr_next  = idx_t'(count_reg - CNT_ONE);
                        end
                        default: begin
                            // Entries above the match move one place lower
                            left_next = count_reg - CNT_ONE - cnt_t'(idx_reg);
                            ptr_next  = idx_t'(idx_inc);
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                // Write back the entry read in the previous cycle
                if (pend_reg) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_data = mem_rd;
                    if (kind_reg == OP_INSERT) begin
                        mem_req.wr_addr = pend_addr_reg + idx_t'(1);
                    end else begin
                        mem_req.wr_addr = pend_addr_reg - idx_t'(1);
                    end
                end
                if (left_reg != '0) begin
                    mem_req.rd_addr = ptr_reg;
                    pend_next       = 1'b1;
                    pend_addr_next  = ptr_reg;
                    left_next       = left_reg - CNT_ONE;
                    if (kind_reg == OP_INSERT) begin
                        ptr_next = ptr_reg - idx_t'(1);
                    end else begin
                        ptr_next = ptr_reg + idx_t'(1);
                    end
                end else begin
                    pend_next = 1'b0;
                    if (kind_reg != OP_INSERT) begin
                        count_next = count_reg - CNT_ONE;
                        result_next.status      = ST_OK;
                        result_next.position    = POS_W'(idx_reg);
                        result_next.entry_count = ECNT_W'(count_reg - CNT_ONE);
                    end
                end
            end
            S_PLACE: begin
                // New record into the opened slot
                mem_req.wr_en       = 1'b1;
                mem_req.wr_addr     = idx_reg;
                mem_req.wr_data.key = key_reg;
                mem_req.wr_data.age = age_reg;
                count_next = count_reg + CNT_ONE;
                result_next.status      = ST_OK;
                result_next.position    = POS_W'(idx_reg);
                result_next.entry_count = ECNT_W'(count_reg + CNT_ONE);
            end
            S_REPLY: begin
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        kind_reg      <= kind_next;
        key_reg       <= key_next;
        age_reg       <= age_next;
        idx_reg       <= idx_next;
        ptr_reg       <= ptr_next;
        left_reg      <= left_next;
        pend_addr_reg <= pend_addr_next;
        result_reg    <= result_next;
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_REPLY);
    assign res_data  = result_reg;

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for sorted_key_table
// Drives search, insert, delete and clear requests through the valid/ready
// request channel and checks every result against a behavioral copy of the
// table. The bench starts with directed corner requests and then runs
// random phases that grow, shrink and churn the table over a small key pool.
// Sender bursts and receiver stall patterns vary throughout the run.
// ----------------------------------------------------------------------------
module tb;
    import skt_pkg::*;

    localparam int RANDOM_REQUESTS = 700;
    localparam int POOL_SIZE       = 24;
    localparam int LONG_HOLD       = 300;
    localparam int SETTLE_CYCLES   = 40;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

    typedef enum int { PH_GROW, PH_SHRINK, PH_CHURN } phase_t;
    typedef enum int { RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_CYCLIC } ready_mode_t;

    // Behavioral table plus the queue of results still owed by the block
    class key_table_checker_t;
        logic signed [KEY_W-1:0] keys [DEPTH];
        logic [AGE_W-1:0]        ages [DEPTH];
        int                      entries;
        out_t                    awaited_replies [$];
        int                      fails;

        function new();
            entries = 0;
            fails   = 0;
        endfunction

        function int outstanding();
            return awaited_replies.size();
        endfunction

        task report(string msg);
            fails++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        // Apply one request to the table and return the result it must give
        function out_t table_outcome(in_t req);
            out_t res;
            int   slot;
            bit   hit;
            res  = '0;
            res.status = ST_OK;
            slot = 0;
            while (slot < entries && keys[slot] < req.key)
                slot++;
            hit = (slot < entries) && (keys[slot] == req.key);
            case (req.kind)
                OP_SEARCH: begin
                    if (hit) begin
                        res.position  = POS_W'(slot);
                        res.found_age = ages[slot];
                    end else begin
                        res.status = ST_NOT_FOUND;
                    end
                end
                OP_INSERT: begin
                    // full is tested ahead of duplicate
                    if (entries >= DEPTH) begin
                        res.status = ST_FULL;
                    end else if (hit) begin
                        res.status = ST_DUP;
                    end else begin
                        for (int j = entries; j > slot; j--) begin
                            keys[j] = keys[j-1];
                            ages[j] = ages[j-1];
                        end
                        keys[slot] = req.key;
                        ages[slot] = req.age;
                        entries++;
                        res.position = POS_W'(slot);
                    end
                end
                OP_DELETE: begin
                    if (hit) begin
                        for (int j = slot; j + 1 < entries; j++) begin
                            keys[j] = keys[j+1];
                            ages[j] = ages[j+1];
                        end
                        entries--;
                        res.position = POS_W'(slot);
                    end else begin
                        res.status = ST_NOT_FOUND;
                    end
                end
                default: begin
                    entries = 0;
                end
            endcase
            res.entry_count = ECNT_W'(entries);
            return res;
        endfunction

        task note_request(in_t req);
            awaited_replies.push_back(table_outcome(req));
        endtask

        task check_result(out_t got);
            out_t want;
            if (awaited_replies.size() == 0) begin
                report($sformatf("result %h with no request pending", got));
                return;
            end
            want = awaited_replies.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.position !== want.position)
                report($sformatf("position %0d, expected %0d",
                                 got.position, want.position));
            if (got.found_age !== want.found_age)
                report($sformatf("found_age %h, expected %h",
                                 got.found_age, want.found_age));
            if (got.entry_count !== want.entry_count)
                report($sformatf("entry_count %0d, expected %0d",
                                 got.entry_count, want.entry_count));
        endtask
    endclass

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    key_table_checker_t sb = new();

    logic signed [KEY_W-1:0] key_pool [POOL_SIZE];
    int burst_left    = 8;
    int hold_requests = 0;

    always #5 aclk = ~aclk;

    sorted_key_table dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Handshake monitor: results are checked before the new request is noted
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_result(m_data);
            if (s_valid && s_ready)
                sb.note_request(s_data);
        end
    end

    // Gap after a burst of requests ends; valid drops only when a gap follows
    task automatic pace();
        int roll;
        int gap;
        burst_left--;
        if (burst_left <= 0) begin
            roll = $urandom_range(0, 99);
            gap  = (roll < 70) ? $urandom_range(1, 4) :
                   (roll < 95) ? $urandom_range(5, 15) : $urandom_range(30, 60);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(1, 40);
        end
    endtask

    task automatic send_op(kind_t kind, logic signed [KEY_W-1:0] key,
                           logic [AGE_W-1:0] age);
        in_t req;
        req.kind = kind;
        req.key  = key;
        req.age  = age;
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        pace();
    endtask

    // Sender holds off until the block has returned everything
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.outstanding() != 0)
            @(posedge aclk);
    endtask

    function automatic logic signed [KEY_W-1:0] extreme_key();
        case ($urandom_range(0, 3))
            0:       return KEY_MIN;
            1:       return KEY_MAX;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    // New key pool per phase: clustered small keys, full-range keys, extremes
    function automatic void refresh_pool();
        int roll;
        for (int i = 0; i < POOL_SIZE; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 40)
                key_pool[i] = 32'($urandom_range(0, 64)) - 32'd32;
            else if (roll < 90)
                key_pool[i] = $urandom;
            else
                key_pool[i] = extreme_key();
        end
    endfunction

    function automatic logic signed [KEY_W-1:0] pick_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 85)
            return key_pool[$urandom_range(0, POOL_SIZE-1)];
        else if (roll < 95)
            return $urandom;
        else
            return extreme_key();
    endfunction

    function automatic kind_t pick_kind(phase_t ph);
        int roll;
        roll = $urandom_range(0, 99);
        case (ph)
            PH_GROW:
                return (roll < 65) ? OP_INSERT : (roll < 85) ? OP_SEARCH :
                       (roll < 98) ? OP_DELETE : OP_CLEAR;
            PH_SHRINK:
                return (roll < 55) ? OP_DELETE : (roll < 80) ? OP_SEARCH :
                       (roll < 97) ? OP_INSERT : OP_CLEAR;
            default:
                return (roll < 35) ? OP_INSERT : (roll < 70) ? OP_SEARCH :
                       (roll < 95) ? OP_DELETE : OP_CLEAR;
        endcase
    endfunction

    // Receiver: stall style changes every stretch; long hold when asked
    initial begin : result_drain
        ready_mode_t mode;
        int span;
        int tick;
        int holds_done;
        mode       = RDY_ALWAYS;
        span       = 0;
        tick       = 0;
        holds_done = 0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (holds_done != hold_requests) begin
                holds_done = hold_requests;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            if (span == 0) begin
                mode = ready_mode_t'($urandom_range(0, 3));
                span = $urandom_range(10, 120);
            end
            span--;
            tick++;
            case (mode)
                RDY_ALWAYS: m_ready <= 1'b1;
                RDY_COIN:   m_ready <= ($urandom_range(0, 1) == 1);
                RDY_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                default:    m_ready <= ((tick % 5) < 2);
            endcase
            @(posedge aclk);
        end
    end

    // Stimulus and end of run
    initial begin : stimulus
        phase_t ph;
        int     phase_no;
        int     sent;
        int     phase_len;
        int     spin;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty table corners
        send_op(OP_SEARCH, '0, 8'h00);
        send_op(OP_DELETE, '0, 8'hFF);
        send_op(OP_CLEAR, KEY_MAX, 8'h00);
        // inserts at the key extremes, then a duplicate
        send_op(OP_INSERT, '0, 8'h5A);
        send_op(OP_INSERT, KEY_MIN, 8'hFF);
        send_op(OP_INSERT, KEY_MAX, 8'h00);
        send_op(OP_INSERT, '1, 8'hA5);
        send_op(OP_INSERT, 32'sd1, 8'h01);
        send_op(OP_INSERT, '0, 8'h03);
        // hits at both ends and inside, a miss in the middle
        send_op(OP_SEARCH, KEY_MIN, 8'h00);
        send_op(OP_SEARCH, KEY_MAX, 8'h00);
        send_op(OP_SEARCH, '1, 8'hFF);
        send_op(OP_SEARCH, 32'sd2, 8'h00);
        // delete middle, missing, last, first
        send_op(OP_DELETE, '0, 8'h00);
        send_op(OP_DELETE, '0, 8'h00);
        send_op(OP_DELETE, KEY_MAX, 8'h00);
        send_op(OP_DELETE, KEY_MIN, 8'h00);
        // clear leaves stale entries that must not be found
        send_op(OP_CLEAR, '0, 8'hFF);
        send_op(OP_SEARCH, '1, 8'h00);
        send_op(OP_INSERT, '1, 8'h77);
        send_op(OP_SEARCH, '1, 8'h00);

        // random phases; the first one is a long grow phase aimed at filling the table
        sent     = 0;
        phase_no = 0;
        while (sent < RANDOM_REQUESTS) begin
            refresh_pool();
            if (phase_no == 0)
                ph = PH_GROW;
            else
                ph = phase_t'($urandom_range(0, 2));
            phase_len = (phase_no == 0) ? 80 : $urandom_range(20, 60);
            if (phase_no == 3) begin
                // receiver stalls long while the sender keeps pushing
                hold_requests++;
                burst_left = 40;
            end
            for (int n = 0; n < phase_len && sent < RANDOM_REQUESTS; n++) begin
                send_op(pick_kind(ph), pick_key(), 8'($urandom_range(0, 255)));
                sent++;
            end
            if (phase_no == 2 || $urandom_range(0, 3) == 0)
                wait_for_drain();
            phase_no++;
        end

        s_valid <= 1'b0;
        for (spin = 0; spin < 5000 && sb.outstanding() != 0; spin++)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.outstanding() != 0)
            sb.report($sformatf("%0d results never returned", sb.outstanding()));

        if (sb.fails == 0) begin
            $display("** sorted_key_table: PASSED **");
        end else begin
            $display("** sorted_key_table: FAILED **");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial begin : watchdog
        #(8_000_000);
        $display("** sorted_key_table: FAILED **");
        $finish;
    end

endmodule
